/* rtl/assert_macros.svh */
// assertion macros used by the node picker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* rtl/lwnp_pkg.sv */
// shared constants and types of the latency weighted node picker
`timescale 1ns / 1ps
package lwnp_pkg;
  localparam int NODES_DEF    = 8;
  localparam int TIE_BITS_DEF = 32;

  localparam int REQ_W   = 3;
  localparam int IDX_W   = 3;
  localparam int WT_W    = 8;
  localparam int LAT_W   = 24;
  localparam int OPEN_W  = 16;
  localparam int ALPHA_W = 9;

  localparam logic [ALPHA_W-1:0] ALPHA_DEF = 9'd51;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // shared multiplier operand and product widths
  localparam int COST_W  = LAT_W + OPEN_W + 1;
  localparam int MUL_A_W = COST_W;
  localparam int MUL_B_W = OPEN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [REQ_W-1:0] REQ_ADD        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PICK       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CONN_START = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CONN_END   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESPONSE   = 3'd5;

  typedef struct packed {
    logic start;
  } mod_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;
endpackage

/* rtl/lwnp_req_if.sv */
// request channel of the node picker
`timescale 1ns / 1ps
interface lwnp_req_if;
  logic                        valid;
  logic                        ready;
  logic [lwnp_pkg::REQ_W-1:0]  req_type;
  logic [lwnp_pkg::IDX_W-1:0]  node_index;
  logic [lwnp_pkg::WT_W-1:0]   weight;
  logic [lwnp_pkg::LAT_W-1:0]  response_time;

  modport source (output valid, req_type, node_index, weight, response_time, input ready);
  modport sink (input valid, req_type, node_index, weight, response_time, output ready);
endinterface

/* rtl/lwnp_res_if.sv */
// result channel of the node picker
`timescale 1ns / 1ps
interface lwnp_res_if;
  logic                        valid;
  logic                        ready;
  logic [lwnp_pkg::IDX_W-1:0]  chosen_node;
  logic                        found;

  modport source (output valid, chosen_node, found, input ready);
  modport sink (input valid, chosen_node, found, output ready);
endinterface

/* rtl/lwnp_mod_unit.sv */
// bit-serial remainder unit for the tie counter modulo the tie count
`timescale 1ns / 1ps
module lwnp_mod_unit #(
  parameter int DW = lwnp_pkg::TIE_BITS_DEF,
  parameter int VW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  lwnp_pkg::mod_ctrl_t ctrl,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output lwnp_pkg::mod_stat_t stat,
  output logic [VW-1:0]       rem
);
  import lwnp_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [VW-1:0] div_r;
  logic [VW:0]   trial;

  assign trial = {rem, dvd[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        dvd   <= dividend;
        div_r <= divisor;
        rem   <= '0;
        cnt   <= '0;
      end else if (busy) begin
        // one quotient bit per cycle, remainder stays below the divisor
        if (trial >= {1'b0, div_r}) begin
          rem <= VW'(trial - {1'b0, div_r});
        end else begin
          rem <= trial[VW-1:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule

/* rtl/latency_weighted_node_picker.sv */
// add, conn start/end, unused codes and a first or ignored response finish in idle; a later
// response runs mul1, mul2 and sum; remove walks the member list to compact it; pick runs
// fetch, cost, lhs, rhs and compare per member on the shared multiplier, then the serial
// modulo (skipped with no members) and the result register, held while the output stalls
// one request at a time: the next is taken once the sequencer is back in idle
// reset (rst, synchronous) clears membership, counts, averages, tie counter, alpha to 51
`timescale 1ns / 1ps
module latency_weighted_node_picker #(
  parameter int NODES            = lwnp_pkg::NODES_DEF,
  parameter int TIE_COUNTER_BITS = lwnp_pkg::TIE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  lwnp_req_if.sink                     req,
  lwnp_res_if.source                   res,
  input logic                          cfg_we,
  input logic [lwnp_pkg::ALPHA_W-1:0]  cfg_data
);
  import lwnp_pkg::*;

  localparam int NIW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNTW = $clog2(NODES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_REM, S_P_FETCH, S_P_COST, S_P_LHS, S_P_RHS, S_P_CMP,
    S_MOD, S_OUT, S_R_MUL1, S_R_MUL2, S_R_SUM
  } state_t;

  state_t state;

  logic [NODES-1:0]  present;
  logic [NODES-1:0]  seen;
  logic [LAT_W-1:0]  lat [NODES];
  logic [OPEN_W-1:0] open_cnt [NODES];
  logic [WT_W-1:0]   wt [NODES];
  logic [NIW-1:0]    order [NODES];
  logic [NIW-1:0]    ties [NODES];
  logic [CNTW-1:0]   member_count;
  logic [CNTW-1:0]   tcount;
  logic [CNTW-1:0]   i;
  logic [CNTW-1:0]   k;
  logic [TIE_COUNTER_BITS-1:0] tie_ctr;
  logic [ALPHA_W-1:0] alpha;

  logic [NIW-1:0]     n_r;
  logic [LAT_W-1:0]   rt_r;
  logic [NIW-1:0]     cur;
  logic [COST_W-1:0]  cost_m;
  logic [COST_W-1:0]  cost_best;
  logic [WT_W-1:0]    div_best;
  logic [PROD_W-1:0]  lhs;
  logic [PROD_W-1:0]  mul_p;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  sum;

  logic [NIW-1:0]   pick_r;
  logic [NIW+2:0]   pick_ext;
  logic             found_r;
  logic             res_valid;
  logic             res_found;
  logic [IDX_W-1:0] chosen_r;

  logic [ALPHA_W-1:0] a_eff;
  logic [ALPHA_W-1:0] a_inv;
  logic               in_range;
  logic [NIW-1:0]     nidx;

  mod_ctrl_t       mod_ctrl;
  mod_stat_t       mod_stat;
  logic [CNTW-1:0] mod_rem;

  lwnp_mod_unit #(.DW(TIE_COUNTER_BITS), .VW(CNTW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mod_ctrl),
    .dividend (tie_ctr),
    .divisor  (tcount),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  assign a_eff    = (alpha == '0 || alpha > ALPHA_ONE) ? ALPHA_DEF : alpha;
  assign a_inv    = ALPHA_ONE - a_eff;
  assign in_range = 32'(req.node_index) < NODES;
  assign nidx     = NIW'(req.node_index);
  assign sum      = lhs + mul_p;
  assign pick_ext = (NIW + 3)'(pick_r);

  assign req.ready       = (state == S_IDLE);
  assign res.valid       = res_valid;
  assign res.chosen_node = chosen_r;
  assign res.found       = res_found;

  // operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_P_COST: begin
        mul_a = MUL_A_W'(lat[cur]);
        mul_b = MUL_B_W'(open_cnt[cur]) + 1'b1;
      end
      S_P_LHS: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = MUL_B_W'(div_best);
      end
      S_P_RHS: begin
        mul_a = cost_best;
        mul_b = MUL_B_W'(wt[cur]);
      end
      S_R_MUL1: begin
        mul_a = MUL_A_W'(rt_r);
        mul_b = MUL_B_W'(a_eff);
      end
      S_R_MUL2: begin
        mul_a = MUL_A_W'(lat[n_r]);
        mul_b = MUL_B_W'(a_inv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (rst) begin
      state          <= S_IDLE;
      present        <= '0;
      seen           <= '0;
      member_count   <= '0;
      tie_ctr        <= '0;
      alpha          <= ALPHA_DEF;
      res_valid      <= 1'b0;
      mod_ctrl.start <= 1'b0;
      tcount         <= '0;
      for (int j = 0; j < NODES; j++) begin
        lat[j]      <= '0;
        open_cnt[j] <= '0;
      end
    end else begin
      mod_ctrl.start <= 1'b0;
      if (cfg_we) begin
        alpha <= cfg_data;
      end
      if (res_valid && res.ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            n_r  <= nidx;
            rt_r <= req.response_time;
            case (req.req_type)
              REQ_PICK: begin
                i      <= '0;
                tcount <= '0;
                state  <= S_P_FETCH;
              end
              REQ_ADD: begin
                if (in_range) begin
                  wt[nidx] <= (req.weight == '0) ? WT_W'(1) : req.weight;
                  if (!present[nidx]) begin
                    present[nidx] <= 1'b1;
                    if (member_count < CNTW'(NODES)) begin
                      order[member_count[NIW-1:0]] <= nidx;
                      member_count <= member_count + 1'b1;
                    end
                  end
                end
              end
              REQ_REMOVE: begin
                if (in_range) begin
                  present[nidx]  <= 1'b0;
                  open_cnt[nidx] <= '0;
                  i              <= '0;
                  k              <= '0;
                  state          <= S_REM;
                end
              end
              REQ_CONN_START: begin
                if (in_range && present[nidx] && open_cnt[nidx] != '1) begin
                  open_cnt[nidx] <= open_cnt[nidx] + 1'b1;
                end
              end
              REQ_CONN_END: begin
                if (in_range && present[nidx] && open_cnt[nidx] != '0) begin
                  open_cnt[nidx] <= open_cnt[nidx] - 1'b1;
                end
              end
              REQ_RESPONSE: begin
                if (in_range && present[nidx] && req.response_time != '0) begin
                  if (!seen[nidx]) begin
                    lat[nidx]  <= req.response_time;
                    seen[nidx] <= 1'b1;
                  end else begin
                    state <= S_R_MUL1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        // compact the member list, keeping order
        S_REM: begin
          if (i < member_count) begin
            if (order[i[NIW-1:0]] != n_r) begin
              order[k[NIW-1:0]] <= order[i[NIW-1:0]];
              k <= k + 1'b1;
            end
            i <= i + 1'b1;
          end else begin
            member_count <= k;
            state        <= S_IDLE;
          end
        end
        S_P_FETCH: begin
          if (i < member_count) begin
            cur <= order[i[NIW-1:0]];
            i   <= i + 1'b1;
            if (present[order[i[NIW-1:0]]]) begin
              state <= S_P_COST;
            end
          end else if (tcount == '0) begin
            pick_r  <= '0;
            found_r <= 1'b0;
            state   <= S_OUT;
          end else begin
            mod_ctrl.start <= 1'b1;
            state          <= S_MOD;
          end
        end
        S_P_COST: begin
          state <= S_P_LHS;
        end
        S_P_LHS: begin
          cost_m <= mul_p[COST_W-1:0];
          if (tcount == '0) begin
            cost_best <= mul_p[COST_W-1:0];
            div_best  <= wt[cur];
            ties[0]   <= cur;
            tcount    <= CNTW'(1);
            state     <= S_P_FETCH;
          end else begin
            state <= S_P_RHS;
          end
        end
        S_P_RHS: begin
          lhs   <= mul_p;
          state <= S_P_CMP;
        end
        // cross-multiplied scores: lhs = cost_m*w_best, mul_p = cost_best*w_m
        S_P_CMP: begin
          if (lhs < mul_p) begin
            cost_best <= cost_m;
            div_best  <= wt[cur];
            ties[0]   <= cur;
            tcount    <= CNTW'(1);
          end else if (lhs == mul_p && tcount < CNTW'(NODES)) begin
            ties[tcount[NIW-1:0]] <= cur;
            tcount <= tcount + 1'b1;
          end
          state <= S_P_FETCH;
        end
        S_MOD: begin
          if (mod_stat.done) begin
            pick_r  <= ties[mod_rem[NIW-1:0]];
            found_r <= 1'b1;
            tie_ctr <= tie_ctr + 1'b1;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_found <= found_r;
            chosen_r  <= pick_ext[IDX_W-1:0];
            state     <= S_IDLE;
          end
        end
        S_R_MUL1: begin
          state <= S_R_MUL2;
        end
        S_R_MUL2: begin
          lhs   <= mul_p;
          state <= S_R_SUM;
        end
        S_R_SUM: begin
          lat[n_r] <= sum[LAT_W+7:8];
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_count_bound, clk, rst, member_count <= CNTW'(NODES), "member count above node count")
  `ASSERT_CLK(a_ready_idle, clk, rst, req.ready |-> !mod_stat.busy, "ready while modulo busy")
  `ASSERT_NEVER(a_mod_stray, clk, rst, mod_stat.done && (state != S_MOD), "stray modulo done")
  `ASSERT_CLK(a_tie_nonzero, clk, rst, (state == S_MOD) |-> (tcount != '0), "modulo by zero ties")
endmodule

/* tb/tb_latency_weighted_node_picker.sv */
// testbench of the latency weighted node picker: directed and random events against a predictor
`timescale 1ns / 1ps
module tb_latency_weighted_node_picker;
  import lwnp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NODE_CNT = 8;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_node;
    logic             found;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ALPHA_W-1:0] cfg_data = '0;

  lwnp_req_if req ();
  lwnp_res_if res ();

  latency_weighted_node_picker i_dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic              member[NODE_CNT];
  logic              seen[NODE_CNT];
  logic [LAT_W-1:0]  lat_avg[NODE_CNT];
  logic [OPEN_W-1:0] open_cnt[NODE_CNT];
  logic [WT_W-1:0]   wt[NODE_CNT];
  logic [IDX_W-1:0]  order[NODE_CNT];
  int                order_len;
  logic [31:0]       rr_count;
  logic [ALPHA_W-1:0] alpha;

  pick_t picks_due[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;
  bit  rx_stall_on = 1;

  function automatic logic [63:0] load_of(int n);
    return 64'(lat_avg[n]) * (64'd1 + 64'(open_cnt[n]));
  endfunction

  task automatic predict_event(logic [REQ_W-1:0] rt, int n, logic [WT_W-1:0] w,
                               logic [LAT_W-1:0] resp);
    int ties[NODE_CNT];
    int tc;
    int best;
    int k;
    int m;
    logic [63:0] lhs, rhs, a, sum;
    pick_t p;
    tc = 0;
    best = 0;
    k = 0;
    case (rt)
      REQ_PICK: begin
        for (int i = 0; i < order_len; i++) begin
          m = order[i];
          if (tc == 0) begin
            best = m; ties[0] = m; tc = 1;
          end else begin
            lhs = load_of(m) * 64'(wt[best]);
            rhs = load_of(best) * 64'(wt[m]);
            if (lhs < rhs) begin
              best = m; ties[0] = m; tc = 1;
            end else if (lhs == rhs) begin
              ties[tc] = m; tc++;
            end
          end
        end
        if (tc == 0) begin
          p.found = 1'b0; p.chosen_node = '0;
        end else begin
          p.found = 1'b1; p.chosen_node = IDX_W'(ties[rr_count % tc]);
          rr_count = rr_count + 1;
        end
        picks_due = {picks_due, p};
      end
      REQ_ADD: begin
        wt[n] = (w == 0) ? 8'd1 : w;
        if (!member[n]) begin
          member[n] = 1'b1; order[order_len] = IDX_W'(n); order_len++;
        end
      end
      REQ_REMOVE: begin
        member[n] = 1'b0;
        open_cnt[n] = '0;
        for (int i = 0; i < order_len; i++)
          if (order[i] != n) begin
            order[k] = order[i]; k++;
          end
        order_len = k;
      end
      REQ_CONN_START: if (member[n] && open_cnt[n] != 16'hffff) open_cnt[n]++;
      REQ_CONN_END: if (member[n] && open_cnt[n] != 0) open_cnt[n]--;
      REQ_RESPONSE: if (resp != 0 && member[n]) begin
        if (!seen[n]) begin
          lat_avg[n] = resp; seen[n] = 1'b1;
        end else begin
          a = (alpha == 0 || alpha > ALPHA_ONE) ? 64'(ALPHA_DEF) : 64'(alpha);
          sum = a * 64'(resp) + (64'd256 - a) * 64'(lat_avg[n]);
          lat_avg[n] = LAT_W'(sum >> 8);
        end
      end
      default: ;
    endcase
  endtask

  task automatic pause(int maxlen);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, maxlen) : $urandom_range(1, 2);
    repeat (n) @(negedge clk);
  endtask

  // valid stays high when the next transaction follows with no gap
  task automatic send_event(logic [REQ_W-1:0] rt, logic [IDX_W-1:0] n,
                            logic [WT_W-1:0] w, logic [LAT_W-1:0] resp);
    req.valid <= 1'b1;
    req.req_type <= rt;
    req.node_index <= n;
    req.weight <= w;
    req.response_time <= resp;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_event(rt, n, w, resp);
    @(negedge clk);
    if ($urandom_range(0, 3) != 0) begin
      req.valid <= 1'b0;
      pause(40);
    end
  endtask

  task automatic drain_and_settle();
    req.valid <= 1'b0;
    while (picks_due.size() != 0 && !timed_out) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_alpha(logic [ALPHA_W-1:0] v);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    alpha = v;
  endtask

  // receive side: random stalls, compare with the oldest pick
  always @(negedge clk) begin
    if (rst || !rx_stall_on) res.ready <= 1'b1;
    else res.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst && res.valid && res.ready) begin
      if (picks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pick transaction: node %0d found %0b",
                                       res.chosen_node, res.found);
      end else begin
        want = picks_due.pop_front();
        if (res.found !== want.found || res.chosen_node !== want.chosen_node) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pick mismatch: expected node %0d found %0b, got node %0d found %0b",
                     want.chosen_node, want.found, res.chosen_node, res.found);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_empty_and_basic();
    send_event(REQ_PICK, 0, 0, 0);
    send_event(REQ_ADD, 3, 0, 0);
    send_event(REQ_ADD, 7, 255, 0);
    send_event(REQ_ADD, 0, 8'h80, 0);
    send_event(REQ_PICK, 0, 0, 0);
    send_event(REQ_PICK, 5, 0, 0);
    send_event(REQ_PICK, 2, 0, 0);
    send_event(REQ_RESPONSE, 3, 0, 24'hffffff);
    send_event(REQ_RESPONSE, 7, 0, 0);
    send_event(REQ_RESPONSE, 7, 0, 24'h000001);
    send_event(REQ_RESPONSE, 3, 0, 24'h123456);
    send_event(REQ_CONN_START, 7, 0, 0);
    send_event(REQ_CONN_END, 0, 0, 0);
    send_event(REQ_CONN_END, 7, 0, 0);
    send_event(REQ_CONN_END, 7, 0, 0);
    send_event(REQ_CONN_START, 5, 0, 0);
    send_event(REQ_ADD, 3, 2, 0);
    send_event(REQ_REMOVE, 0, 0, 0);
    send_event(REQ_REMOVE, 4, 0, 0);
    send_event(3'd6, 1, 0, 0);
    send_event(3'd7, 1, 0, 0);
    send_event(REQ_PICK, 0, 0, 0);
    send_event(REQ_ADD, 0, 1, 0);
    send_event(REQ_PICK, 0, 0, 0);
  endtask

  // count connection starts and ends on one node, ends running below zero
  task automatic test_conn_counts();
    send_event(REQ_ADD, 1, 1, 0);
    send_event(REQ_RESPONSE, 1, 0, 24'h000200);
    rx_stall_on = 0;
    repeat (20) send_event(REQ_CONN_START, 1, 0, 0);
    send_event(REQ_PICK, 0, 0, 0);
    repeat (24) send_event(REQ_CONN_END, 1, 0, 0);
    rx_stall_on = 1;
    send_event(REQ_PICK, 0, 0, 0);
    send_event(REQ_REMOVE, 1, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [REQ_W-1:0] rt;
    int r;
    for (int i = 0; i < count && !timed_out; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) rt = REQ_ADD;
      else if (r < 18) rt = REQ_REMOVE;
      else if (r < 40) rt = REQ_PICK;
      else if (r < 55) rt = REQ_CONN_START;
      else if (r < 67) rt = REQ_CONN_END;
      else if (r < 97) rt = REQ_RESPONSE;
      else rt = REQ_W'($urandom_range(6, 7));
      send_event(rt, IDX_W'($urandom_range(0, 7)),
                 ($urandom_range(0, 4) == 0) ? WT_W'($urandom_range(0, 3)) : WT_W'($urandom),
                 ($urandom_range(0, 9) == 0) ? '0 :
                 ($urandom_range(0, 1) ? LAT_W'($urandom) : LAT_W'($urandom_range(1, 2000))));
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.req_type = '0;
    req.node_index = '0;
    req.weight = '0;
    req.response_time = '0;
    res.ready = 1'b0;
    for (int i = 0; i < NODE_CNT; i++) begin
      member[i] = 0; seen[i] = 0; lat_avg[i] = '0; open_cnt[i] = '0; wt[i] = '0; order[i] = '0;
    end
    order_len = 0;
    rr_count = '0;
    alpha = ALPHA_DEF;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_and_basic();
    test_conn_counts();
    test_random(350);
    write_alpha(9'd1);
    test_random(300);
    write_alpha(9'd256);
    test_random(300);
    write_alpha(9'd0);
    test_random(150);
    write_alpha(9'd511);
    test_random(150);
    write_alpha(9'd128);
    test_random(250);
    drain_and_settle();
    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
